>>> hdl/fsfe_pkg.sv
`timescale 1ns / 1ps

package fsfe_pkg;

	localparam int FB_PIXELS = 16384;
	localparam int FB_AW     = $clog2(FB_PIXELS);
	localparam int MAX_WIDTH = 256;
	localparam int COLOR_W   = 16;

	// signed linear address: wide enough for the longest run at the widest stride
	localparam int ADDR_W = 25;
	// signed per-pixel step: up to one column plus one row
	localparam int STEP_W = 11;
	localparam int CNT_W  = 16;
	localparam int WCNT_W = 15;
	localparam int ROWW_W = 9;

	localparam logic [ROWW_W-1:0] ROW_WIDTH_RST = ROWW_W'(128);

	typedef enum logic [2:0] {
		CMD_HRUN   = 3'd0,
		CMD_VRUN   = 3'd1,
		CMD_HLINE  = 3'd2,
		CMD_VLINE  = 3'd3,
		CMD_DIAG   = 3'd4,
		CMD_RECT   = 3'd5,
		CMD_READ   = 3'd6,
		CMD_UNUSED = 3'd7
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_en;
		logic load_in;
		logic setup;
		logic run;
		logic load_result;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic run_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> hdl/fsfe_ctrl.sv
`timescale 1ns / 1ps

module fsfe_ctrl
	import fsfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctl_cmd_t   ctl
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_READ  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = status.is_read ? ST_READ : ST_RUN;
			end
			ST_RUN: begin
				ctl.run = 1'b1;
				if (status.run_done) begin
					state_d = ST_FIN;
				end
			end
			ST_READ: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					ctl.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> hdl/fsfe_dp.sv
`timescale 1ns / 1ps

module fsfe_dp
	import fsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             ctl,
	output dp_status_t           status,
	input  logic [ROWW_W-1:0]    row_width,
	input  logic [2:0]           command,
	input  logic [15:0]          color,
	input  logic [7:0]           start_u,
	input  logic [7:0]           start_v,
	input  logic [7:0]           end_u,
	input  logic [7:0]           end_v,
	input  logic signed [15:0]   run_length,
	input  logic                 step_right,
	input  logic                 step_down,
	input  logic [8:0]           diag_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          read_color,
	output logic [14:0]          pixels_written,
	output logic                 out_of_range
);

	// frame memory
	logic [COLOR_W-1:0] mem [FB_PIXELS];
	logic [COLOR_W-1:0] rd_data_q;
	logic               mem_we;
	logic [FB_AW-1:0]   mem_wa;
	logic [COLOR_W-1:0] mem_wd;
	logic [FB_AW-1:0]   clr_addr_q;

	// captured item
	cmd_t               cmd_q;
	logic [COLOR_W-1:0] color_q;
	logic [7:0]         u0_q, v0_q, u1_q, v1_q;
	logic [15:0]        rl_q;
	logic               right_q, down_q;
	logic [8:0]         dcount_q;

	// walk state
	logic signed [ADDR_W-1:0] addr_q, row_base_q;
	logic signed [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [8:0]               ucnt_q;
	logic [8:0]               rows_left_q;
	logic [WCNT_W-1:0]        wr_cnt_q;
	logic                     oor_q;

	logic                     out_valid_q;
	logic [15:0]              read_color_q;
	logic [WCNT_W-1:0]        pixels_written_q;
	logic                     out_of_range_q;

	// setup arithmetic
	logic [ROWW_W-1:0]        w;
	logic signed [STEP_W-1:0] w_s, one_s;
	logic [7:0]               ulo, vlo, udiff, vdiff, vsel, usel;
	logic [8:0]               ucnt, vcnt;
	logic [16:0]              base;
	logic [15:0]              rl_abs;
	logic                     rl_pos;
	logic                     in_range;
	logic                     cnt_nz;
	logic                     next_row;
	logic signed [ADDR_W-1:0] step_ext;
	logic signed [ADDR_W-1:0] w_ext;

	assign w = (row_width > ROWW_W'(MAX_WIDTH)) ? ROWW_W'(MAX_WIDTH) : row_width;
	assign w_s   = signed'(STEP_W'(w));
	assign one_s = signed'(STEP_W'(1));
	assign w_ext = signed'(ADDR_W'(w));

	assign ulo   = (u0_q < u1_q) ? u0_q : u1_q;
	assign vlo   = (v0_q < v1_q) ? v0_q : v1_q;
	assign udiff = (u0_q < u1_q) ? (u1_q - u0_q) : (u0_q - u1_q);
	assign vdiff = (v0_q < v1_q) ? (v1_q - v0_q) : (v0_q - v1_q);
	assign ucnt  = {1'b0, udiff} + 9'd1;
	assign vcnt  = {1'b0, vdiff} + 9'd1;

	assign vsel = (cmd_q == CMD_RECT) ? vlo : v0_q;
	assign usel = (cmd_q == CMD_RECT) ? ulo : u0_q;
	assign base = 17'(w * vsel) + {9'd0, usel};

	assign rl_pos = !rl_q[15] && (rl_q != '0);
	assign rl_abs = rl_q[15] ? (~rl_q + 16'd1) : rl_q;

	assign in_range = (addr_q[ADDR_W-1:FB_AW] == '0);
	assign cnt_nz   = (cnt_q != '0);
	assign next_row = !cnt_nz && (cmd_q == CMD_RECT) && (rows_left_q > 9'd1);
	assign step_ext = {{(ADDR_W-STEP_W){step_q[STEP_W-1]}}, step_q};

	assign status.clr_last = &clr_addr_q;
	assign status.is_read  = (cmd_q == CMD_READ);
	assign status.run_done = !cnt_nz && !next_row;
	assign status.out_free = !out_valid_q || !out_stall;

	// memory ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q[FB_AW-1:0];
		mem_wd = color_q;
		if (ctl.clr_en) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (ctl.run && cnt_nz && in_range) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[addr_q[FB_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (ctl.clr_en) begin
			clr_addr_q <= clr_addr_q + FB_AW'(1);
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q    <= cmd_t'(command);
			color_q  <= COLOR_W'(color);
			u0_q     <= start_u;
			v0_q     <= start_v;
			u1_q     <= end_u;
			v1_q     <= end_v;
			rl_q     <= run_length;
			right_q  <= step_right;
			down_q   <= step_down;
			dcount_q <= diag_count;
		end
	end

	// walk: setup then one pixel per cycle, pausing to step rows in a rectangle
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			addr_q      <= signed'(ADDR_W'(base));
			row_base_q  <= signed'(ADDR_W'(base));
			ucnt_q      <= ucnt;
			rows_left_q <= '0;
			wr_cnt_q    <= '0;
			oor_q       <= 1'b0;
			step_q      <= one_s;
			cnt_q       <= '0;
			case (cmd_q)
				CMD_HRUN: begin
					step_q <= rl_pos ? one_s : -one_s;
					cnt_q  <= rl_abs;
				end
				CMD_VRUN: begin
					step_q <= rl_pos ? w_s : -w_s;
					cnt_q  <= rl_abs;
				end
				CMD_HLINE: begin
					step_q <= (u0_q < u1_q) ? one_s : -one_s;
					cnt_q  <= CNT_W'(ucnt);
				end
				CMD_VLINE: begin
					step_q <= (v0_q < v1_q) ? w_s : -w_s;
					cnt_q  <= CNT_W'(vcnt);
				end
				CMD_DIAG: begin
					step_q <= (right_q ? one_s : -one_s) + (down_q ? w_s : -w_s);
					cnt_q  <= CNT_W'(dcount_q);
				end
				CMD_RECT: begin
					cnt_q       <= CNT_W'(ucnt);
					rows_left_q <= vcnt;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end else if (ctl.run) begin
			if (cnt_nz) begin
				if (in_range) begin
					if (wr_cnt_q != '1) begin
						wr_cnt_q <= wr_cnt_q + WCNT_W'(1);
					end
				end else begin
					oor_q <= 1'b1;
				end
				addr_q <= addr_q + step_ext;
				cnt_q  <= cnt_q - CNT_W'(1);
			end else if (next_row) begin
				row_base_q  <= row_base_q + w_ext;
				addr_q      <= row_base_q + w_ext;
				cnt_q       <= CNT_W'(ucnt_q);
				rows_left_q <= rows_left_q - 9'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			if (cmd_q == CMD_READ) begin
				read_color_q     <= in_range ? 16'(rd_data_q) : '0;
				pixels_written_q <= '0;
				out_of_range_q   <= !in_range;
			end else begin
				read_color_q     <= '0;
				pixels_written_q <= wr_cnt_q;
				out_of_range_q   <= oor_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign read_color     = read_color_q;
	assign pixels_written = pixels_written_q;
	assign out_of_range   = out_of_range_q;

endmodule

>>> hdl/framebuffer_span_fill_engine.sv
`timescale 1ns / 1ps
// Flow: an accepted command is set up, walks its pixels (stepping to the next row
//   between rectangle rows) and posts its result; a read-pixel command reads its pixel.
// Throughput: one pixel per cycle through the single memory write port, pausing at each
//   rectangle row step; one command at a time: no new command is taken until the result
//   is posted, later while the previous result is stalled.
// Reset (arst_n low, async): row_width returns to 128 and the frame memory is
//   swept to zero with in_stall high; register writes still land.
module framebuffer_span_fill_engine
	import fsfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// command items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [15:0]        color,
	input  logic [7:0]         start_u,
	input  logic [7:0]         start_v,
	input  logic [7:0]         end_u,
	input  logic [7:0]         end_v,
	input  logic signed [15:0] run_length,
	input  logic               step_right,
	input  logic               step_down,
	input  logic [8:0]         diag_count,

	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        read_color,
	output logic [14:0]        pixels_written,
	output logic               out_of_range,

	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [ROWW_W-1:0] row_width_q;
	ctl_cmd_t          ctl;
	dp_status_t        status;

	// row_width sits at byte address 0; address 4 reads zero, writes ignored
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			row_width_q <= pwdata[ROWW_W-1:0];
		end
	end

	assign prdata = paddr[2] ? '0 : {{(32-ROWW_W){1'b0}}, row_width_q};

	// sequencer: clear sweep, then take one command, walk it or read its pixel, post result
	fsfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// address walker, frame memory and result register
	fsfe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.status         (status),
		.row_width      (row_width_q),
		.command        (command),
		.color          (color),
		.start_u        (start_u),
		.start_v        (start_v),
		.end_u          (end_u),
		.end_v          (end_v),
		.run_length     (run_length),
		.step_right     (step_right),
		.step_down      (step_down),
		.diag_count     (diag_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_color     (read_color),
		.pixels_written (pixels_written),
		.out_of_range   (out_of_range)
	);

endmodule

>>> hdl/fsfe_checker.sv
`timescale 1ns / 1ps

module fsfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] read_color,
	input logic [14:0] pixels_written,
	input logic        out_of_range
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one command at a time: engine is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken back to back");

	// a nonzero read color only comes from a good read, which writes nothing
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_color != 16'd0) |-> !out_of_range && (pixels_written == 15'd0))
		else $error("read result mixed with write status");

endmodule

bind framebuffer_span_fill_engine fsfe_checker u_fsfe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.read_color     (read_color),
	.pixels_written (pixels_written),
	.out_of_range   (out_of_range)
);
